// File: sv/length_prefixed_message_deframer_assert.svh
// Assertion macros for the length-prefixed message deframer.
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LPMD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");
`define LPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");
`else
`define LPMD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/lpmd_pkg.sv
// Shared types and constants of the length-prefixed message deframer.
`default_nettype none
package lpmd_pkg;

  localparam int WORD_BYTES      = 8;
  localparam int WORD_W          = WORD_BYTES * 8;
  localparam int BODY_INDEX_BITS = 16;
  localparam int ID_W            = 64;
  localparam int NUM_W           = 16;
  localparam int POS_W           = 5;
  localparam int Q_DEPTH         = 2;
  localparam int Q_PTR_W         = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_OVERRUN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic {
    BK_FIRST = 1'b0,
    BK_END   = 1'b1
  } back_state_t;

  typedef logic [WORD_W-1:0]          word_t;
  typedef logic [BODY_INDEX_BITS-1:0] body_index_t;

  typedef struct packed {
    logic              has_res;
    kind_t             kind;
    logic [ID_W-1:0]   message_id;
    logic [ID_W-1:0]   application_id;
    logic [7:0]        payload_byte;
    logic [NUM_W-1:0]  body_number;
    logic              body_final;
    logic              has_end;
    status_t           status;
  } cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   message_id;
    logic [ID_W-1:0]   application_id;
    logic [7:0]        payload_byte;
    logic [NUM_W-1:0]  body_number;
    logic              body_final;
    status_t           status;
    logic              last;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [NUM_W-1:0] num_out(input body_index_t idx);
    logic [BODY_INDEX_BITS+NUM_W-1:0] wide;
    wide = (BODY_INDEX_BITS + NUM_W)'(idx);
    return wide[NUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/lpmd_if.sv
// Stream interfaces for the deframer's byte input and result output.
`default_nettype none
interface lpmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface lpmd_out_if;
  import lpmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [ID_W-1:0]  message_id;
  logic [ID_W-1:0]  application_id;
  logic [7:0]       payload_byte;
  logic [NUM_W-1:0] body_number;
  logic             body_final;
  logic [1:0]       status;
  logic             last;

  modport source (output valid, output kind, output message_id, output application_id,
                  output payload_byte, output body_number, output body_final,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input message_id, input application_id,
                  input payload_byte, input body_number, input body_final,
                  input status, input last, output ready);
endinterface
`default_nettype wire

// File: sv/length_prefixed_message_deframer.sv
// Top level of the length-prefixed message deframer.
// The in_stream channel carries one message byte per transfer, with
// end_of_message set on the final byte. The out_stream channel carries one
// result per transfer: the header with both 64-bit ids, each body byte with
// its body number and last-of-body flag, an empty-body marker, and the end
// status of the message. The last flag marks the final result of one byte.
// A byte that yields results is written as a command into the queue, and
// its first result then goes through the output register to out_stream.
// One byte is taken every cycle while the queue is not full; the parse state
// in the front end is updated at the edge that takes the byte. A final byte
// that also completes a header, an empty body or a body byte yields two
// results from one entry of the two-entry command queue, sent in order.
// Reset is synchronous and active low: it returns the parser to the start
// of a message and empties the queue and the output register.
// When the receiver holds ready low, the output register keeps its result,
// the queue fills, and in_stream.ready drops once the queue is full.
`default_nettype none
`include "length_prefixed_message_deframer_assert.svh"
module length_prefixed_message_deframer (
  input  wire         clk,
  input  wire         rst_n,
  lpmd_in_if.sink     in_stream,
  lpmd_out_if.source  out_stream
);
  import lpmd_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head_cmd;

  lpmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (push_cmd)
  );

  lpmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  lpmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_stream (out_stream)
  );

  `LPMD_ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, push, !q_stat.full)
  `LPMD_ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst_n, pop, !q_stat.empty)
  `LPMD_ASSERT_IMPLIES(a_end_is_last, clk, rst_n,
    out_stream.valid && out_stream.kind == KIND_END, out_stream.last)
  `LPMD_ASSERT_IMPLIES(a_final_only_on_body, clk, rst_n,
    out_stream.valid && out_stream.kind != KIND_BODY, !out_stream.body_final)

endmodule
`default_nettype wire

// File: sv/lpmd_front.sv
// Front end: takes message bytes, tracks parse state and issues result commands.
`default_nettype none
module lpmd_front (
  input  wire              clk,
  input  wire              rst_n,
  lpmd_in_if.sink          in_stream,
  input  lpmd_pkg::q_stat_t q_stat,
  output logic             push,
  output lpmd_pkg::cmd_t   cmd
);
  import lpmd_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] byte_position_r, byte_position_nxt;
  word_t            first_word_r, first_word_nxt;
  word_t            shift_word_r, shift_word_nxt;
  word_t            bytes_left_r, bytes_left_nxt;
  body_index_t      body_index_r, body_index_nxt;

  logic             accept;
  word_t            shifted;
  logic [POS_W-1:0] pos_inc;
  logic             fin;
  body_index_t      bumped;

  assign in_stream.ready = !q_stat.full;
  assign accept          = in_stream.valid && in_stream.ready;
  assign push            = accept && (cmd.has_res || cmd.has_end);

  always_comb begin
    shifted = WORD_W'({shift_word_r, in_stream.data_byte});
    pos_inc = byte_position_r + POS_W'(1);
    fin     = bytes_left_r <= WORD_W'(1);
    bumped  = (body_index_r != '1) ? body_index_r + BODY_INDEX_BITS'(1) : body_index_r;

    phase_nxt         = phase_r;
    byte_position_nxt = byte_position_r;
    first_word_nxt    = first_word_r;
    shift_word_nxt    = shift_word_r;
    bytes_left_nxt    = bytes_left_r;
    body_index_nxt    = body_index_r;
    cmd               = '0;
    cmd.kind          = KIND_HEADER;
    cmd.status        = ST_OK;

    unique case (phase_r)
      PH_BODY: begin
        cmd.has_res      = 1'b1;
        cmd.kind         = KIND_BODY;
        cmd.payload_byte = in_stream.data_byte;
        cmd.body_number  = num_out(body_index_r);
        cmd.body_final   = fin;
        if (fin) begin
          bytes_left_nxt    = '0;
          body_index_nxt    = bumped;
          phase_nxt         = PH_LENGTH;
          byte_position_nxt = '0;
          shift_word_nxt    = '0;
        end else begin
          bytes_left_nxt = bytes_left_r - WORD_W'(1);
          if (in_stream.end_of_message) begin
            cmd.status = ST_OVERRUN;
          end
        end
      end
      PH_LENGTH: begin
        shift_word_nxt    = shifted;
        byte_position_nxt = pos_inc;
        if (pos_inc >= POS_W'(WORD_BYTES)) begin
          bytes_left_nxt    = shifted;
          shift_word_nxt    = '0;
          byte_position_nxt = '0;
          if (shifted == '0) begin
            cmd.has_res     = 1'b1;
            cmd.kind        = KIND_EMPTY;
            cmd.body_number = num_out(body_index_r);
            body_index_nxt  = bumped;
          end else begin
            phase_nxt = PH_BODY;
            if (in_stream.end_of_message) begin
              cmd.status = ST_OVERRUN;
            end
          end
        end
      end
      default: begin
        shift_word_nxt    = shifted;
        byte_position_nxt = pos_inc;
        if (pos_inc == POS_W'(WORD_BYTES)) begin
          first_word_nxt = shifted;
          shift_word_nxt = '0;
        end
        if (pos_inc >= POS_W'(2 * WORD_BYTES)) begin
          cmd.has_res        = 1'b1;
          cmd.kind           = KIND_HEADER;
          cmd.message_id     = ID_W'(first_word_r);
          cmd.application_id = ID_W'(shifted);
          shift_word_nxt     = '0;
          byte_position_nxt  = '0;
          phase_nxt          = PH_LENGTH;
        end else if (in_stream.end_of_message) begin
          cmd.status = ST_SHORT;
        end
      end
    endcase

    if (in_stream.end_of_message) begin
      cmd.has_end       = 1'b1;
      phase_nxt         = PH_HEADER;
      byte_position_nxt = '0;
      first_word_nxt    = '0;
      shift_word_nxt    = '0;
      bytes_left_nxt    = '0;
      body_index_nxt    = '0;
    end else begin
      cmd.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      byte_position_r <= '0;
      first_word_r    <= '0;
      shift_word_r    <= '0;
      bytes_left_r    <= '0;
      body_index_r    <= '0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      byte_position_r <= byte_position_nxt;
      first_word_r    <= first_word_nxt;
      shift_word_r    <= shift_word_nxt;
      bytes_left_r    <= bytes_left_nxt;
      body_index_r    <= body_index_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/lpmd_queue.sv
// Short command queue between the deframer's front and back ends.
`default_nettype none
module lpmd_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  lpmd_pkg::cmd_t     push_cmd,
  input  wire                pop,
  output lpmd_pkg::cmd_t     head_cmd,
  output lpmd_pkg::q_stat_t  q_stat
);
  import lpmd_pkg::*;

  cmd_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full  = count_r == Q_CNT_W'(Q_DEPTH);
  assign q_stat.empty = count_r == '0;
  assign head_cmd     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/lpmd_back.sv
// Back end: expands queued commands into result transfers through an output register.
`default_nettype none
module lpmd_back (
  input  wire                clk,
  input  wire                rst_n,
  input  lpmd_pkg::cmd_t     head_cmd,
  input  lpmd_pkg::q_stat_t  q_stat,
  output logic               pop,
  lpmd_out_if.source         out_stream
);
  import lpmd_pkg::*;

  back_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_data_r, out_data_nxt;
  logic        load;
  logic        head_valid;

  assign head_valid = !q_stat.empty;
  assign load       = !out_valid_r || out_stream.ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        if (state_r == BK_FIRST && head_cmd.has_res) begin
          out_data_nxt.kind           = head_cmd.kind;
          out_data_nxt.message_id     = head_cmd.message_id;
          out_data_nxt.application_id = head_cmd.application_id;
          out_data_nxt.payload_byte   = head_cmd.payload_byte;
          out_data_nxt.body_number    = head_cmd.body_number;
          out_data_nxt.body_final     = head_cmd.body_final;
          out_data_nxt.status         = ST_OK;
          out_data_nxt.last           = !head_cmd.has_end;
          if (head_cmd.has_end) begin
            state_nxt = BK_END;
          end else begin
            pop = 1'b1;
          end
        end else begin
          out_data_nxt        = '0;
          out_data_nxt.kind   = KIND_END;
          out_data_nxt.status = head_cmd.status;
          out_data_nxt.last   = 1'b1;
          pop                 = 1'b1;
          state_nxt           = BK_FIRST;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_stream.valid          = out_valid_r;
  assign out_stream.kind           = out_data_r.kind;
  assign out_stream.message_id     = out_data_r.message_id;
  assign out_stream.application_id = out_data_r.application_id;
  assign out_stream.payload_byte   = out_data_r.payload_byte;
  assign out_stream.body_number    = out_data_r.body_number;
  assign out_stream.body_final     = out_data_r.body_final;
  assign out_stream.status         = out_data_r.status;
  assign out_stream.last           = out_data_r.last;

endmodule
`default_nettype wire

// File: tb/sv/tb_length_prefixed_message_deframer.sv
// Self-checking testbench of the length-prefixed message deframer with its own parse predictor.
module tb_length_prefixed_message_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import lpmd_pkg::*;

  localparam int RUN_LIMIT       = 2_500_000;
  localparam int RANDOM_BYTES    = 1800;
  localparam int SHOWN_ERRORS    = 10;
  localparam int SETTLE_CYCLES   = 20;

  typedef struct {
    logic [7:0] data;
    logic       eom;
    bit         drain;
    bit         steady;
  } stream_byte_t;

  typedef enum {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_STRETCH,
    RDY_PERIODIC
  } ready_mode_t;

  logic clk;
  logic rst_n;

  lpmd_in_if  byte_in ();
  lpmd_out_if res_out ();

  length_prefixed_message_deframer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (byte_in),
    .out_stream (res_out)
  );

  stream_byte_t byte_backlog[$];
  logic [7:0]   msg_bytes[$];
  res_t         expected_results[$];
  int           mismatch_count = 0;
  bit           in_fired = 1'b0;
  int unsigned  cycle_count;

  phase_t           parse_phase    = PH_HEADER;
  logic [POS_W-1:0] parse_pos      = '0;
  word_t            msg_id_word    = '0;
  word_t            shift_acc      = '0;
  word_t            body_remaining = '0;
  body_index_t      body_count     = '0;

  int          burst_left   = 0;
  int          gap_left     = 0;
  ready_mode_t ready_mode   = RDY_ALWAYS;
  int          mode_left    = 0;
  int          stretch_left = 0;
  logic        ready_level  = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic string res_text(input res_t r);
    return $sformatf("kind=%0d mid=%h aid=%h byte=%h num=%0d fin=%0b st=%0d last=%0b",
                     r.kind, r.message_id, r.application_id, r.payload_byte,
                     r.body_number, r.body_final, r.status, r.last);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS) begin
      $display("%s", what);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic eom);
    res_t    found[$];
    res_t    r;
    status_t end_status;
    logic    done;
    end_status = ST_OK;
    r = '0;
    if (parse_phase == PH_BODY) begin
      done = (body_remaining <= WORD_W'(1));
      r.kind = KIND_BODY;
      r.payload_byte = b;
      r.body_number = body_count;
      r.body_final = done;
      found = {found, r};
      if (done) begin
        body_remaining = '0;
        body_count = (body_count == '1) ? body_count : body_count + BODY_INDEX_BITS'(1);
        parse_phase = PH_LENGTH;
        parse_pos = '0;
        shift_acc = '0;
      end else begin
        body_remaining = body_remaining - WORD_W'(1);
        if (eom) begin
          end_status = ST_OVERRUN;
        end
      end
    end else begin
      shift_acc = {shift_acc[WORD_W-9:0], b};
      parse_pos = parse_pos + POS_W'(1);
      if (parse_phase == PH_LENGTH) begin
        if (parse_pos >= POS_W'(WORD_BYTES)) begin
          body_remaining = shift_acc;
          shift_acc = '0;
          parse_pos = '0;
          if (body_remaining == '0) begin
            r.kind = KIND_EMPTY;
            r.body_number = body_count;
            found = {found, r};
            body_count = (body_count == '1) ? body_count : body_count + BODY_INDEX_BITS'(1);
          end else begin
            parse_phase = PH_BODY;
            if (eom) begin
              end_status = ST_OVERRUN;
            end
          end
        end
      end else begin
        if (parse_pos == POS_W'(WORD_BYTES)) begin
          msg_id_word = shift_acc;
          shift_acc = '0;
        end
        if (parse_pos >= POS_W'(2 * WORD_BYTES)) begin
          r.kind = KIND_HEADER;
          r.message_id = msg_id_word;
          r.application_id = shift_acc;
          found = {found, r};
          shift_acc = '0;
          parse_pos = '0;
          parse_phase = PH_LENGTH;
        end else if (eom) begin
          end_status = ST_SHORT;
        end
      end
    end
    if (eom) begin
      r = '0;
      r.kind = KIND_END;
      r.status = end_status;
      found = {found, r};
      parse_phase = PH_HEADER;
      parse_pos = '0;
      msg_id_word = '0;
      shift_acc = '0;
      body_remaining = '0;
      body_count = '0;
    end
    if (found.size() > 0) begin
      found[found.size()-1].last = 1'b1;
    end
    foreach (found[i]) begin
      expected_results = {expected_results, found[i]};
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t seen;
    res_t want;
    if (rst_n) begin
      if (res_out.valid && res_out.ready) begin
        seen.kind = kind_t'(res_out.kind);
        seen.message_id = res_out.message_id;
        seen.application_id = res_out.application_id;
        seen.payload_byte = res_out.payload_byte;
        seen.body_number = res_out.body_number;
        seen.body_final = res_out.body_final;
        seen.status = status_t'(res_out.status);
        seen.last = res_out.last;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result at %0t: %s", $realtime, res_text(seen)));
        end else begin
          want = expected_results.pop_front();
          if (seen.kind !== want.kind || seen.message_id !== want.message_id ||
              seen.application_id !== want.application_id ||
              seen.payload_byte !== want.payload_byte ||
              seen.body_number !== want.body_number || seen.body_final !== want.body_final ||
              seen.status !== want.status || seen.last !== want.last) begin
            report_mismatch($sformatf("mismatch at %0t\n  expected %s\n  actual   %s",
                                      $realtime, res_text(want), res_text(seen)));
          end
        end
      end
      if (byte_in.valid && byte_in.ready) begin
        deframe_byte(byte_in.data_byte, byte_in.end_of_message);
      end
      in_fired <= byte_in.valid && byte_in.ready;
    end
  end

  always @(negedge clk) begin : byte_driver
    stream_byte_t nx;
    logic         send;
    send = 1'b0;
    if (!rst_n) begin
      byte_in.valid <= 1'b0;
    end else if (!(byte_in.valid && !in_fired)) begin
      if (byte_backlog.size() > 0 && byte_backlog[0].steady) begin
        gap_left = 0;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (byte_backlog.size() > 0 &&
                   !(byte_backlog[0].drain && expected_results.size() != 0)) begin
        nx = byte_backlog.pop_front();
        byte_in.data_byte <= nx.data;
        byte_in.end_of_message <= nx.eom;
        send = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      byte_in.valid <= send;
    end
  end

  always @(negedge clk) begin : ready_pattern
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 400);
    end
    mode_left--;
    case (ready_mode)
      RDY_ALWAYS: begin
        res_out.ready <= 1'b1;
      end
      RDY_COIN: begin
        res_out.ready <= 1'($urandom_range(0, 1));
      end
      RDY_STRETCH: begin
        if (stretch_left == 0) begin
          ready_level = !ready_level;
          stretch_left = ready_level ? $urandom_range(1, 4) : $urandom_range(1, 6);
        end
        stretch_left--;
        res_out.ready <= ready_level;
      end
      default: begin
        res_out.ready <= (mode_left % 5) != 0;
      end
    endcase
  end

  task automatic push_word(input word_t w);
    for (int i = WORD_BYTES - 1; i >= 0; i--) begin
      msg_bytes = {msg_bytes, w[8*i +: 8]};
    end
  endtask

  task automatic push_random(input int n);
    repeat (n) msg_bytes = {msg_bytes, 8'($urandom)};
  endtask

  task automatic send_message(input bit drain, input bit steady);
    stream_byte_t sb;
    foreach (msg_bytes[i]) begin
      sb.data = msg_bytes[i];
      sb.eom = (i == msg_bytes.size() - 1);
      sb.drain = drain && (i == 0);
      sb.steady = steady;
      byte_backlog = {byte_backlog, sb};
    end
    msg_bytes.delete();
  endtask

  function automatic word_t random_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int body_length();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      return 0;
    end else if (pick < 4) begin
      return 1;
    end else if (pick < 9) begin
      return $urandom_range(2, 8);
    end
    return $urandom_range(9, 40);
  endfunction

  task automatic queue_random_message(input bit drain);
    int    bodies;
    int    ending;
    int    len;
    int    cut;
    word_t size_word;
    if ($urandom_range(0, 4) == 0) begin
      push_random($urandom_range(1, 40));
      send_message(drain, 1'b0);
      return;
    end
    ending = $urandom_range(0, 5);
    if (ending == 5) begin
      push_random($urandom_range(1, 2 * WORD_BYTES - 1));
      send_message(drain, 1'b0);
      return;
    end
    push_word(random_word());
    push_word(random_word());
    bodies = $urandom_range(0, 4);
    repeat (bodies) begin
      len = body_length();
      push_word(word_t'(len));
      push_random(len);
    end
    case (ending)
      1: begin
        push_random($urandom_range(1, WORD_BYTES - 1));
      end
      2: begin
        size_word = random_word();
        if (size_word == '0) begin
          size_word = word_t'(1);
        end
        push_word(size_word);
      end
      3: begin
        push_word('0);
      end
      4: begin
        size_word = $urandom_range(0, 1) ? word_t'($urandom_range(2, 30)) : random_word();
        if (size_word < 2) begin
          size_word = word_t'(2);
        end
        cut = (size_word > 30) ? $urandom_range(1, 30) : $urandom_range(1, int'(size_word) - 1);
        push_word(size_word);
        push_random(cut);
      end
      default: begin
      end
    endcase
    send_message(drain, 1'b0);
  endtask

  initial begin : stimulus
    int base;
    rst_n = 1'b0;
    byte_in.valid = 1'b0;
    byte_in.data_byte = '0;
    byte_in.end_of_message = 1'b0;
    res_out.ready = 1'b0;

    msg_bytes = {msg_bytes, 8'hFF};
    send_message(1'b0, 1'b0);
    push_word('1);
    push_word('0);
    send_message(1'b1, 1'b0);

    base = byte_backlog.size();
    while (byte_backlog.size() - base < RANDOM_BYTES) begin
      queue_random_message($urandom_range(0, 19) == 0);
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (byte_backlog.size() != 0 || byte_in.valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("** length_prefixed_message_deframer: PASSED **");
    end else begin
      $display("** length_prefixed_message_deframer: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) @(posedge clk);
    $display("** length_prefixed_message_deframer: FAILED **");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/lpmd_pkg.sv
sv/lpmd_if.sv
sv/lpmd_front.sv
sv/lpmd_queue.sv
sv/lpmd_back.sv
sv/length_prefixed_message_deframer.sv
tb/sv/tb_length_prefixed_message_deframer.sv
